>>> rtl/kknp_pkg.sv
// ----------------------------------------------------------------------------
// kknp_pkg
// Shared types and constants of the nearest-points keeper: word layouts of
// the item and result channels, field widths, register indexes, FSM states.
// ----------------------------------------------------------------------------
package kknp_pkg;

  localparam int COORD_W = 16;
  localparam int TAG_W   = 32;
  localparam int DIST_W  = 34;
  localparam int SQ_W    = 32;
  localparam int SLOT_W  = 5;
  localparam int KEPT_W  = 6;
  localparam int ADDR_W  = 3;
  localparam int DATA_W  = 32;

  localparam logic REG_CENTER_X = 1'b0;
  localparam logic REG_CENTER_Y = 1'b1;

  typedef struct packed {
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic        [TAG_W-1:0]   point_tag;
    logic                      first_of_set;
  } item_t;

  typedef struct packed {
    logic                stored;
    logic [SLOT_W-1:0]   slot;
    logic                evicted;
    logic [TAG_W-1:0]    evicted_tag;
    logic [KEPT_W-1:0]   kept_count;
    logic [DIST_W-1:0]   farthest_distance;
  } result_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_SUM,
    ST_DECIDE,
    ST_SCAN
  } state_t;

endpackage

>>> rtl/kknp_dist.sv
// ----------------------------------------------------------------------------
// kknp_dist
// Three-stage squared-distance pipeline: differences, squares, sum.
// ----------------------------------------------------------------------------
module kknp_dist (
  input  logic                               clk,
  input  logic signed [kknp_pkg::COORD_W-1:0] point_x,
  input  logic signed [kknp_pkg::COORD_W-1:0] point_y,
  input  logic signed [kknp_pkg::COORD_W-1:0] center_x,
  input  logic signed [kknp_pkg::COORD_W-1:0] center_y,
  output logic        [kknp_pkg::DIST_W-1:0]  distance
);
  import kknp_pkg::*;

  logic signed [COORD_W:0]     dx;
  logic signed [COORD_W:0]     dy;
  logic signed [2*COORD_W+1:0] prod_x;
  logic signed [2*COORD_W+1:0] prod_y;
  logic        [SQ_W-1:0]      sq_x;
  logic        [SQ_W-1:0]      sq_y;

  assign prod_x = dx * dx;
  assign prod_y = dy * dy;

  always_ff @(posedge clk) begin
    dx       <= {point_x[COORD_W-1], point_x} - {center_x[COORD_W-1], center_x};
    dy       <= {point_y[COORD_W-1], point_y} - {center_y[COORD_W-1], center_y};
    sq_x     <= prod_x[SQ_W-1:0];
    sq_y     <= prod_y[SQ_W-1:0];
    distance <= DIST_W'(sq_x) + DIST_W'(sq_y);
  end

endmodule

>>> rtl/kknp_cell.sv
// ----------------------------------------------------------------------------
// kknp_cell
// One slot of the store. Holds a distance and a tag, and passes on the
// running farthest entry seen so far along the chain, lowest slot on ties.
// ----------------------------------------------------------------------------
module kknp_cell #(
  parameter int IDX_W = 5,
  parameter int INDEX = 0
) (
  input  logic                         clk,
  input  logic                         wr_en,
  input  logic [IDX_W-1:0]             wr_slot,
  input  logic [kknp_pkg::DIST_W-1:0]  wr_dist,
  input  logic [kknp_pkg::TAG_W-1:0]   wr_tag,
  input  logic [kknp_pkg::DIST_W-1:0]  cin_dist,
  input  logic [IDX_W-1:0]             cin_slot,
  input  logic [kknp_pkg::TAG_W-1:0]   cin_tag,
  output logic [kknp_pkg::DIST_W-1:0]  cout_dist,
  output logic [IDX_W-1:0]             cout_slot,
  output logic [kknp_pkg::TAG_W-1:0]   cout_tag
);
  import kknp_pkg::*;

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

  logic [DIST_W-1:0] distance;
  logic [TAG_W-1:0]  tag;

  always_ff @(posedge clk) begin
    if (wr_en && wr_slot == MY_IDX) begin
      distance <= wr_dist;
      tag      <= wr_tag;
    end
    if (distance > cin_dist) begin
      cout_dist <= distance;
      cout_slot <= MY_IDX;
      cout_tag  <= tag;
    end else begin
      cout_dist <= cin_dist;
      cout_slot <= cin_slot;
      cout_tag  <= cin_tag;
    end
  end

endmodule

>>> rtl/keep_k_nearest_points.sv
// ----------------------------------------------------------------------------
// keep_k_nearest_points
// Keeps the KEEP points nearest to a programmable center.
//
// Item channel: drive item and raise start; the word is taken at a clock
// edge with start high and busy low. Busy stays high until the result for
// that word has been shown.
// Result channel: done is high for one cycle with result; the receiver
// cannot stall, so it must take the word in that cycle.
// Config: APB port, center_x at address 0, center_y at address 4, both
// 16-bit signed in pwdata[15:0]; write only while idle.
// Sequence: an accepted word passes the SQUARE, SUM and DECIDE states; done
// is registered from DECIDE when the point is appended or dropped, else from
// SCAN, once the farthest search has run down the chain of KEEP slot cells.
// One word is in flight at a time.
// Reset: rst (synchronous) empties the store and clears the center to 0.
// ----------------------------------------------------------------------------
module keep_k_nearest_points #(
  parameter int KEEP = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  kknp_pkg::item_t               item,
  output logic                          done,
  output kknp_pkg::result_t             result,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [kknp_pkg::ADDR_W-1:0]   paddr,
  input  logic [kknp_pkg::DATA_W-1:0]   pwdata,
  output logic [kknp_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);
  import kknp_pkg::*;

  localparam int IDX_W = $clog2(KEEP);
  localparam int CNT_W = $clog2(KEEP + 1);
  localparam logic [CNT_W-1:0] KEEP_CNT = CNT_W'(KEEP);

  state_t state;
  state_t state_next;

  logic signed [COORD_W-1:0] center_x;
  logic signed [COORD_W-1:0] center_y;

  logic [CNT_W-1:0]  held_count;
  logic [DIST_W-1:0] max_dist;
  logic [IDX_W-1:0]  max_slot;
  logic [TAG_W-1:0]  max_tag;
  logic [TAG_W-1:0]  point_tag;
  logic [CNT_W-1:0]  scan_cnt;
  logic [DIST_W-1:0] distance;

  logic              accept;
  logic              cfg_wr;
  logic              is_fill;
  logic              is_repl;
  logic              grows;
  logic              cell_wr;
  logic [IDX_W-1:0]  wr_slot;
  logic              scan_done;
  logic [CNT_W-1:0]  held_inc;

  logic [DIST_W-1:0] chain_dist [KEEP];
  logic [IDX_W-1:0]  chain_slot [KEEP];
  logic [TAG_W-1:0]  chain_tag  [KEEP];

  assign accept   = start && !busy;
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign pready   = 1'b1;
  assign prdata   = (paddr[2] == REG_CENTER_Y) ? DATA_W'(center_y) : DATA_W'(center_x);
  assign held_inc = held_count + 1'b1;

  kknp_dist u_dist (
    .clk      (clk),
    .point_x  (item.point_x),
    .point_y  (item.point_y),
    .center_x (center_x),
    .center_y (center_y),
    .distance (distance)
  );

  for (genvar i = 0; i < KEEP; i++) begin : g_cell
    if (i == 0) begin : g_head
      kknp_cell #(.IDX_W(IDX_W), .INDEX(i)) u_cell (
        .clk       (clk),
        .wr_en     (cell_wr),
        .wr_slot   (wr_slot),
        .wr_dist   (distance),
        .wr_tag    (point_tag),
        .cin_dist  ('0),
        .cin_slot  ('0),
        .cin_tag   ('0),
        .cout_dist (chain_dist[i]),
        .cout_slot (chain_slot[i]),
        .cout_tag  (chain_tag[i])
      );
    end else begin : g_body
      kknp_cell #(.IDX_W(IDX_W), .INDEX(i)) u_cell (
        .clk       (clk),
        .wr_en     (cell_wr),
        .wr_slot   (wr_slot),
        .wr_dist   (distance),
        .wr_tag    (point_tag),
        .cin_dist  (chain_dist[i-1]),
        .cin_slot  (chain_slot[i-1]),
        .cin_tag   (chain_tag[i-1]),
        .cout_dist (chain_dist[i]),
        .cout_slot (chain_slot[i]),
        .cout_tag  (chain_tag[i])
      );
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (start) state_next = ST_SQUARE;
      ST_SQUARE: state_next = ST_SUM;
      ST_SUM:    state_next = ST_DECIDE;
      ST_DECIDE: state_next = is_repl ? ST_SCAN : ST_IDLE;
      ST_SCAN:   if (scan_done) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    busy      = (state != ST_IDLE);
    is_fill   = (held_count < KEEP_CNT);
    is_repl   = !is_fill && (distance < max_dist);
    grows     = distance > max_dist;
    cell_wr   = (state == ST_DECIDE) && (is_fill || is_repl);
    wr_slot   = is_fill ? held_count[IDX_W-1:0] : max_slot;
    scan_done = (state == ST_SCAN) && (scan_cnt == KEEP_CNT);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      center_x   <= '0;
      center_y   <= '0;
      held_count <= '0;
      max_dist   <= '0;
      max_slot   <= '0;
      scan_cnt   <= '0;
      done       <= 1'b0;
    end else begin
      state <= state_next;
      done  <= ((state == ST_DECIDE) && !is_repl) || scan_done;
      if (cfg_wr) begin
        if (paddr[2] == REG_CENTER_X) center_x <= pwdata[COORD_W-1:0];
        else                          center_y <= pwdata[COORD_W-1:0];
      end
      if (accept && item.first_of_set) begin
        held_count <= '0;
        max_dist   <= '0;
        max_slot   <= '0;
      end
      if (state == ST_DECIDE) begin
        scan_cnt <= '0;
        if (is_fill) begin
          held_count <= held_inc;
          if (grows) begin
            max_dist <= distance;
            max_slot <= held_count[IDX_W-1:0];
          end
        end
      end
      if (state == ST_SCAN) begin
        scan_cnt <= scan_cnt + 1'b1;
      end
      if (scan_done) begin
        max_dist <= chain_dist[KEEP-1];
        max_slot <= chain_slot[KEEP-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) point_tag <= item.point_tag;
    if (state == ST_DECIDE) begin
      if (is_fill) begin
        if (grows) max_tag <= point_tag;
        result.stored            <= 1'b1;
        result.slot              <= SLOT_W'(held_count[IDX_W-1:0]);
        result.evicted           <= 1'b0;
        result.evicted_tag       <= '0;
        result.kept_count        <= KEPT_W'(held_inc);
        result.farthest_distance <= grows ? distance : max_dist;
      end else if (is_repl) begin
        result.stored            <= 1'b1;
        result.slot              <= SLOT_W'(max_slot);
        result.evicted           <= 1'b1;
        result.evicted_tag       <= max_tag;
        result.kept_count        <= KEPT_W'(held_count);
        result.farthest_distance <= max_dist;
      end else begin
        result.stored            <= 1'b0;
        result.slot              <= '0;
        result.evicted           <= 1'b0;
        result.evicted_tag       <= '0;
        result.kept_count        <= KEPT_W'(held_count);
        result.farthest_distance <= max_dist;
      end
    end
    if (scan_done) begin
      max_tag                  <= chain_tag[KEEP-1];
      result.farthest_distance <= chain_dist[KEEP-1];
    end
  end

endmodule

>>> sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for keep_k_nearest_points. Point words are fed through
// the start/busy port with random gaps; every accepted word is run through a
// local model of the nearest-points store, and each done strobe is checked
// field by field against the oldest prediction. The center is reprogrammed
// over APB between phases, extremes included, and read back.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import kknp_pkg::*;

  localparam int KEEP_SLOTS = 32;
  localparam int STALL_LIMIT = 2000;

  typedef enum int {SET_WIDE, SET_NEAR, SET_CENTER, SET_CORNER} set_mode_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  item_t item = '0;
  logic done;
  result_t result;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic pready;

  keep_k_nearest_points #(.KEEP(KEEP_SLOTS)) u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .item(item),
    .done(done), .result(result), .psel(psel), .penable(penable),
    .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
    .pready(pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // local copy of the store
  logic signed [COORD_W-1:0] ctr_x = '0;
  logic signed [COORD_W-1:0] ctr_y = '0;
  logic [DIST_W-1:0] kept_dist [KEEP_SLOTS];
  logic [TAG_W-1:0] kept_tag [KEEP_SLOTS];
  int held_cnt = 0;
  logic [DIST_W-1:0] far_dist = '0;
  int far_slot = 0;

  item_t pending_items[$];
  result_t expected_results[$];
  int words_queued = 0;
  int words_taken = 0;
  int results_seen = 0;
  int mismatches = 0;
  int n_appended = 0;
  int n_replaced = 0;
  int n_dropped = 0;
  int sets_issued = 0;
  int centers_used = 1;
  bit quiet = 1'b0;
  int gap_left = 0;
  int stall_cycles = 0;

  function automatic result_t predict_nearest(item_t it);
    result_t r;
    longint dx, dy;
    logic [DIST_W-1:0] d;
    r = '0;
    if (it.first_of_set) begin
      held_cnt = 0;
      far_dist = '0;
      far_slot = 0;
    end
    dx = longint'($signed(it.point_x)) - longint'(ctr_x);
    dy = longint'($signed(it.point_y)) - longint'(ctr_y);
    d = DIST_W'(dx * dx + dy * dy);
    if (held_cnt < KEEP_SLOTS) begin
      kept_dist[held_cnt] = d;
      kept_tag[held_cnt] = it.point_tag;
      r.stored = 1'b1;
      r.slot = SLOT_W'(held_cnt);
      if (d > far_dist) begin
        far_dist = d;
        far_slot = held_cnt;
      end
      held_cnt++;
      n_appended++;
    end else if (d < far_dist) begin
      r.stored = 1'b1;
      r.slot = SLOT_W'(far_slot);
      r.evicted = 1'b1;
      r.evicted_tag = kept_tag[far_slot];
      kept_dist[far_slot] = d;
      kept_tag[far_slot] = it.point_tag;
      far_dist = '0;
      far_slot = 0;
      for (int i = 0; i < held_cnt; i++) begin
        if (kept_dist[i] > far_dist) begin
          far_dist = kept_dist[i];
          far_slot = i;
        end
      end
      n_replaced++;
    end else begin
      n_dropped++;
    end
    r.kept_count = KEPT_W'(held_cnt);
    r.farthest_distance = far_dist;
    return r;
  endfunction

  task automatic note_mismatch(string what, logic [79:0] want, logic [79:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch %s: expected %h, got %h", what, want, got);
  endtask

  task automatic compare_field(string what, logic [79:0] want, logic [79:0] got);
    if (want !== got) note_mismatch(what, want, got);
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
      gap_left = 0;
    end else begin
      if (start && !busy) begin
        expected_results.push_back(predict_nearest(item));
        words_taken++;
      end
      if (start && busy) begin
      end else if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
        item <= {$urandom(), $urandom(), 1'($urandom())};
      end else if (pending_items.size() > 0) begin
        item <= pending_items.pop_front();
        start <= 1'b1;
        if (!quiet && $urandom_range(0, 5) == 0) gap_left = $urandom_range(1, 12);
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    result_t want;
    if (!rst && done) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        note_mismatch("result with nothing pending", '0, result);
      end else begin
        want = expected_results.pop_front();
        compare_field("stored", want.stored, result.stored);
        compare_field("slot", want.slot, result.slot);
        compare_field("evicted", want.evicted, result.evicted);
        compare_field("evicted_tag", want.evicted_tag, result.evicted_tag);
        compare_field("kept_count", want.kept_count, result.kept_count);
        compare_field("farthest_distance", want.farthest_distance,
                      result.farthest_distance);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("timeout after %0d cycles without progress", stall_cycles);
        $display("FAIL keep_k_nearest_points");
        $finish;
      end
    end
  end

  task automatic apb_access(input logic wr, input logic [ADDR_W-1:0] addr,
                            input logic [DATA_W-1:0] wdata,
                            output logic [DATA_W-1:0] rdata);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= addr;
    pwdata <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    rdata = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic program_center(input int x, input int y);
    logic [DATA_W-1:0] rd;
    logic [COORD_W-1:0] vx, vy;
    vx = COORD_W'(x);
    vy = COORD_W'(y);
    apb_access(1'b1, ADDR_W'(REG_CENTER_X) << 2, {{16{vx[15]}}, vx}, rd);
    apb_access(1'b1, ADDR_W'(REG_CENTER_Y) << 2, {{16{vy[15]}}, vy}, rd);
    ctr_x = vx;
    ctr_y = vy;
    apb_access(1'b0, ADDR_W'(REG_CENTER_X) << 2, '0, rd);
    compare_field("center_x readback", vx, rd[15:0]);
    apb_access(1'b0, ADDR_W'(REG_CENTER_Y) << 2, '0, rd);
    compare_field("center_y readback", vy, rd[15:0]);
    centers_used++;
  endtask

  task automatic push_word(input int x, input int y, input logic [TAG_W-1:0] tag,
                           input logic fos);
    item_t it;
    it.point_x = COORD_W'(x);
    it.point_y = COORD_W'(y);
    it.point_tag = tag;
    it.first_of_set = fos;
    pending_items.push_back(it);
    words_queued++;
  endtask

  function automatic int clamp_coord(int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  task automatic add_set(input set_mode_t mode, input int len, input logic fresh);
    int spread, x, y;
    logic fos;
    case ($urandom_range(0, 3))
      0: spread = 1;
      1: spread = 2;
      2: spread = 4;
      default: spread = 300;
    endcase
    for (int i = 0; i < len; i++) begin
      x = int'($signed(16'($urandom())));
      y = int'($signed(16'($urandom())));
      case (mode)
        SET_NEAR: begin
          x = clamp_coord(int'(ctr_x) + int'($urandom_range(0, 2 * spread)) - spread);
          y = clamp_coord(int'(ctr_y) + int'($urandom_range(0, 2 * spread)) - spread);
        end
        SET_CENTER: begin
          if (i < KEEP_SLOTS || $urandom_range(0, 1)) begin
            x = int'(ctr_x);
            y = int'(ctr_y);
          end
        end
        SET_CORNER: begin
          if ($urandom_range(0, 3) != 0) begin
            x = $urandom_range(0, 1) ? 32767 : -32768;
            y = $urandom_range(0, 1) ? 32767 : -32768;
          end
        end
        default: begin
        end
      endcase
      fos = (i == 0) ? fresh : ($urandom_range(0, 59) == 0);
      push_word(x, y, $urandom(), fos);
    end
    sets_issued++;
  endtask

  task automatic fill_phase(input int target, input logic fresh);
    int issued, len;
    set_mode_t mode;
    logic first;
    issued = 0;
    first = 1'b1;
    while (issued < target) begin
      mode = set_mode_t'($urandom_range(0, 3));
      len = ($urandom_range(0, 9) < 7) ? $urandom_range(33, 100) : $urandom_range(1, 32);
      if (mode == SET_CENTER && len < KEEP_SLOTS + 4) len = KEEP_SLOTS + $urandom_range(4, 40);
      add_set(mode, len, first ? fresh : 1'b1);
      first = 1'b0;
      issued += len;
    end
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (words_taken != words_queued || expected_results.size() != 0);
    repeat (KEEP_SLOTS + 8) @(posedge clk);
  endtask

  initial begin
    int cx [6];
    int cy [6];
    cx = '{32767, -32768, 32767, -32768, 0, 0};
    cy = '{32767, -32768, -32768, 32767, 0, 0};
    cx[4] = int'($urandom_range(0, 65535)) - 32768;
    cy[4] = int'($urandom_range(0, 65535)) - 32768;

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // reset center, extremes and zero distance
    push_word(-32768, -32768, 32'h0000_0000, 1'b1);
    push_word(32767, 32767, 32'hFFFF_FFFF, 1'b0);
    push_word(0, 0, 32'h1234_5678, 1'b0);
    push_word(-32768, 32767, 32'hA5A5_A5A5, 1'b0);
    push_word(32767, -32768, 32'h5A5A_5A5A, 1'b0);
    push_word(1, 0, 32'h0000_0001, 1'b1);
    push_word(0, -1, 32'h8000_0000, 1'b0);
    push_word(-1, 0, 32'h7FFF_FFFF, 1'b0);
    push_word(0, 0, 32'hDEAD_0001, 1'b1);
    push_word(0, 0, 32'hDEAD_0002, 1'b0);
    push_word(5, -5, 32'hDEAD_0003, 1'b1);
    push_word(-5, 5, 32'hDEAD_0004, 1'b0);
    fill_phase(170, 1'b1);
    wait_drained();

    for (int p = 0; p < 6; p++) begin
      program_center(cx[p], cy[p]);
      if (p == 5) quiet = 1'b1;
      fill_phase(250, p % 2 == 0);
      wait_drained();
    end

    $display("%0d point words in %0d sets checked, %0d results: %0d appended,",
             words_taken, sets_issued, results_seen, n_appended);
    $display("%0d replaced, %0d dropped, across %0d center settings",
             n_replaced, n_dropped, centers_used);
    if (mismatches == 0) begin
      $display("PASS keep_k_nearest_points");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("FAIL keep_k_nearest_points");
    end
    $finish;
  end

endmodule
